### rtl/tlj_pkg.sv
// Shared widths, register map and reset values for the text line justifier.
`default_nettype none

package tlj_pkg;

  localparam int LEN_W  = 7;   // word length field
  localparam int SP_W   = 6;   // spaces field
  localparam int DATA_W = 32;  // config data bus
  localparam int ADDR_W = 3;   // config address bus

  localparam logic [ADDR_W-1:0] LINE_WIDTH_ADDR = 3'd0;
  localparam logic [LEN_W-1:0]  LINE_WIDTH_RST  = 7'd16;

endpackage

`default_nettype wire

### rtl/tlj_if.sv
// Valid/ready channel interfaces for word lengths in and placed words out.
`default_nettype none

interface tlj_word_if
  import tlj_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] word_length;
  logic             final_word;

  modport source (output valid, output word_length, output final_word, input ready);
  modport sink   (input valid, input word_length, input final_word, output ready);
endinterface

interface tlj_place_if
  import tlj_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] placed_length;
  logic [SP_W-1:0]  spaces_after;
  logic             line_end;
  logic             too_long;
  logic             run_last;

  modport source (output valid, output placed_length, output spaces_after,
                  output line_end, output too_long, output run_last, input ready);
  modport sink   (input valid, input placed_length, input spaces_after,
                  input line_end, input too_long, input run_last, output ready);
endinterface

`default_nettype wire

### rtl/text_line_justifier_unit.sv
// Top level of the greedy full text justifier.
`default_nettype none

// Takes word lengths one transfer at a time and returns one result per placed
// or dropped word. A word that joins the open line without closing it returns
// nothing. Closing a justified line of two or more words first runs the serial
// divider (even spacing and remainder), then reads one word per cycle from
// the line store into the output register while the output is not stalled; a
// left-justified close does the same without the divider. The input is not
// ready while an item is being worked on.
// line_width is written over APB at address 0 and should only change while
// the block is idle.
module text_line_justifier_unit
  import tlj_pkg::*;
#(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_WORDS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  tlj_word_if.sink               words,
  tlj_place_if.source            places,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_JUST,
    S_APPEND,
    S_LEFT,
    S_BAD
  } state_t;

  state_t            state;
  logic [LEN_W-1:0]  line_width;
  logic [LEN_W-1:0]  mem [MAX_WORDS];
  logic [CW-1:0]     count;
  logic [WW-1:0]     span;
  logic [AW-1:0]     idx;
  logic [LEN_W-1:0]  w_reg;
  logic              do_left;
  logic              is_bad;
  logic              div_go;

  logic [LEN_W-1:0]  eff7;
  logic [WW-1:0]     width_eff;
  logic [LEN_W:0]    wid8;
  logic [LEN_W:0]    in_sum;
  logic [LEN_W:0]    reg_sum;
  logic [LEN_W:0]    in_span;
  logic              in_bad;
  logic              in_close;
  logic              in_left;
  logic [EW-1:0]     extra;
  logic [AW-1:0]     gaps;
  logic [EW-1:0]     each;
  logic [AW-1:0]     rem;
  logic              div_done;
  logic              last;
  logic              lt_rem;
  logic [EW:0]       just_sp;
  logic              out_load;
  logic              out_fire;
  logic              accept;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr == LINE_WIDTH_ADDR) ? DATA_W'(line_width) : '0;

  assign eff7 = (line_width == '0) ? LEN_W'(1) :
                (line_width > LEN_W'(MAX_WIDTH)) ? LEN_W'(MAX_WIDTH) : line_width;
  assign width_eff = WW'(eff7);
  assign wid8      = (LEN_W + 1)'(width_eff);

  // Decisions taken when a word is accepted
  assign in_sum   = (LEN_W + 1)'(span) + (LEN_W + 1)'(1) + {1'b0, words.word_length};
  assign in_bad   = (words.word_length == '0) || ({1'b0, words.word_length} > wid8);
  assign in_close = (count >= CW'(MAX_WORDS)) || ((count != '0) && (in_sum > wid8));
  assign in_span  = (in_close || (count == '0)) ? {1'b0, words.word_length} : in_sum;
  assign in_left  = in_bad ? (words.final_word && (count != '0))
                           : ((in_span == wid8) || words.final_word);

  assign reg_sum = (LEN_W + 1)'(span) + (LEN_W + 1)'(1) + {1'b0, w_reg};

  assign extra = (span <= width_eff) ? EW'(width_eff - span) : '0;
  assign gaps  = AW'(count - CW'(1));

  tlj_div #(
    .DW (EW),
    .VW (AW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (extra),
    .divisor  (gaps),
    .quot     (each),
    .rem      (rem),
    .done     (div_done)
  );

  assign last    = (CW'(idx) == (count - CW'(1)));
  assign lt_rem  = (CW'(idx) < CW'(rem));
  assign just_sp = {1'b0, each} + (EW + 1)'(1) + (EW + 1)'(lt_rem);

  assign out_load    = !places.valid || places.ready;
  assign out_fire    = out_load &&
                       ((state == S_JUST) || (state == S_LEFT) || (state == S_BAD));
  assign words.ready = (state == S_IDLE);
  assign accept      = words.valid && words.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      line_width   <= LINE_WIDTH_RST;
      count        <= '0;
      span         <= '0;
      idx          <= '0;
      div_go       <= 1'b0;
      places.valid <= 1'b0;
    end else begin
      div_go <= accept && !in_bad && in_close && (count != CW'(1));
      if (psel && penable && pwrite && (paddr == LINE_WIDTH_ADDR)) begin
        line_width <= pwdata[LEN_W-1:0];
      end
      if (out_fire) begin
        places.valid <= 1'b1;
      end else if (places.ready) begin
        places.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          idx <= '0;
          if (accept) begin
            w_reg   <= words.word_length;
            is_bad  <= in_bad;
            do_left <= in_left;
            if (in_bad) begin
              state <= in_left ? S_LEFT : S_BAD;
            end else if (in_close) begin
              if (count == CW'(1)) begin
                state <= S_JUST;
              end else begin
                state <= S_DIV;
              end
            end else begin
              state <= S_APPEND;
            end
          end
        end

        S_DIV: begin
          if (div_done) begin
            state <= S_JUST;
          end
        end

        S_JUST: begin
          if (out_load) begin
            places.placed_length <= mem[idx];
            places.too_long      <= 1'b0;
            places.line_end      <= last;
            places.run_last      <= last && !do_left;
            if (count == CW'(1)) begin
              places.spaces_after <= SP_W'(extra);
            end else if (last) begin
              places.spaces_after <= '0;
            end else begin
              places.spaces_after <= SP_W'(just_sp);
            end
            if (last) begin
              count <= '0;
              span  <= '0;
              idx   <= '0;
              state <= S_APPEND;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end

        S_APPEND: begin
          mem[count[AW-1:0]] <= w_reg;
          count <= count + CW'(1);
          span  <= (count == '0) ? WW'(w_reg) : WW'(reg_sum);
          idx   <= '0;
          state <= do_left ? S_LEFT : S_IDLE;
        end

        S_LEFT: begin
          if (out_load) begin
            places.placed_length <= mem[idx];
            places.too_long      <= 1'b0;
            places.line_end      <= last;
            places.run_last      <= last && !is_bad;
            places.spaces_after  <= last ? SP_W'(extra) : SP_W'(1);
            if (last) begin
              count <= '0;
              span  <= '0;
              idx   <= '0;
              state <= is_bad ? S_BAD : S_IDLE;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end

        S_BAD: begin
          if (out_load) begin
            places.placed_length <= w_reg;
            places.spaces_after  <= '0;
            places.line_end      <= 1'b0;
            places.too_long      <= 1'b1;
            places.run_last      <= 1'b1;
            state                <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/tlj_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module tlj_div #(
  parameter int DW = 6,
  parameter int VW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic      [DW-1:0] quot,
  output logic      [VW-1:0] rem,
  output logic               done
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [CNT_W-1:0] cnt;
  logic [VW:0]      shift;
  logic             ge;
  logic [VW-1:0]    diff;
  logic [VW-1:0]    rem_next;
  logic [DW-1:0]    qs;

  assign shift    = {rem, quot[DW-1]};
  assign ge       = shift >= {1'b0, divisor};
  assign diff     = VW'(shift - {1'b0, divisor});
  assign rem_next = ge ? diff : shift[VW-1:0];
  assign qs       = {quot[DW-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quot <= dividend;
        cnt  <= CNT_W'(DW);
      end else if (cnt != '0) begin
        rem  <= rem_next;
        quot <= qs;
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### tb/tb_top.sv
// Testbench for text_line_justifier_unit: directed and random word streams checked against a line predictor.
module tb_top
  import tlj_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_WORDS  = 32;
  localparam int QUIET_MAX  = 3000;
  localparam int RAND_SETS  = 9;
  localparam int SET_WORDS  = 22;

  typedef struct {
    logic [LEN_W-1:0] len;
    logic             fin;
  } word_item_t;

  typedef struct {
    logic [LEN_W-1:0] placed_length;
    logic [SP_W-1:0]  spaces_after;
    logic             line_end;
    logic             too_long;
    logic             run_last;
  } place_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tlj_word_if  words_if ();
  tlj_place_if places_if ();

  text_line_justifier_unit dut (
    .clk     (clk),
    .rst     (rst),
    .words   (words_if),
    .places  (places_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  word_item_t       text_words[$];
  place_t           placements_due[$];
  logic [LEN_W-1:0] width_reg = LINE_WIDTH_RST;
  int unsigned      open_len [MAX_WORDS];
  int unsigned      open_cnt = 0;
  int unsigned      open_span = 0;

  logic word_fired = 1'b0;
  int   gap_pct = 13;
  int   stall_pct = 13;
  int   fail_count = 0;
  int   words_taken = 0;
  int   places_seen = 0;
  int   dropped_seen = 0;
  int   lines_seen = 0;
  int   widths_used = 0;
  int   quiet_cycles = 0;

  // ---------------- line predictor ----------------
  function automatic int unsigned active_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic void push_place(int unsigned len, int unsigned sp, bit eol, bit bad);
    place_t p;
    p.placed_length = LEN_W'(len);
    p.spaces_after  = SP_W'(sp);
    p.line_end      = eol;
    p.too_long      = bad;
    p.run_last      = 1'b0;
    placements_due  = {placements_due, p};
  endfunction

  function automatic void close_ragged(int unsigned w);
    int unsigned pad;
    if (open_cnt == 0) return;
    pad = (open_span <= w) ? w - open_span : 0;
    for (int unsigned k = 0; k + 1 < open_cnt; k++) push_place(open_len[k], 1, 0, 0);
    push_place(open_len[open_cnt-1], pad, 1, 0);
    open_cnt  = 0;
    open_span = 0;
  endfunction

  function automatic void close_even(int unsigned w);
    int unsigned extra;
    int unsigned gaps;
    int unsigned each;
    int unsigned rem;
    if (open_cnt == 0) return;
    extra = (open_span <= w) ? w - open_span : 0;
    if (open_cnt == 1) begin
      push_place(open_len[0], extra, 1, 0);
    end else begin
      gaps = open_cnt - 1;
      each = extra / gaps;
      rem  = extra % gaps;
      for (int unsigned k = 0; k < gaps; k++)
        push_place(open_len[k], 1 + each + ((k < rem) ? 1 : 0), 0, 0);
      push_place(open_len[gaps], 0, 1, 0);
    end
    open_cnt  = 0;
    open_span = 0;
  endfunction

  function automatic void justify_word(logic [LEN_W-1:0] len, logic fin);
    int unsigned w;
    int unsigned first;
    w     = active_width();
    first = placements_due.size();
    if (len == 0 || len > w) begin
      if (fin) close_ragged(w);
      push_place(len, 0, 0, 1);
    end else begin
      if (open_cnt >= MAX_WORDS || (open_cnt > 0 && open_span + 1 + len > w))
        close_even(w);
      open_span = (open_cnt == 0) ? len : open_span + 1 + len;
      open_len[open_cnt] = len;
      open_cnt++;
      if (open_span == w || fin) close_ragged(w);
    end
    if (placements_due.size() > first) placements_due[placements_due.size()-1].run_last = 1'b1;
  endfunction

  // ---------------- driver ----------------
  always @(negedge clk) begin : drive
    word_item_t nxt;
    if (rst) begin
      words_if.valid  <= 1'b0;
      places_if.ready <= 1'b0;
    end else begin
      if (!words_if.valid || word_fired) begin
        if (text_words.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          nxt = text_words.pop_front();
          words_if.valid       <= 1'b1;
          words_if.word_length <= nxt.len;
          words_if.final_word  <= nxt.fin;
        end else begin
          words_if.valid <= 1'b0;
        end
      end
      places_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin : watch
    place_t want;
    word_fired <= words_if.valid && words_if.ready;
    if (!rst) begin
      if (words_if.valid && words_if.ready) begin
        justify_word(words_if.word_length, words_if.final_word);
        words_taken++;
      end
      if (places_if.valid && places_if.ready) begin
        places_seen++;
        if (places_if.too_long) dropped_seen++;
        if (places_if.line_end) lines_seen++;
        if (placements_due.size() == 0) begin
          $error("placed word transfer with nothing expected: len %0d", places_if.placed_length);
          fail_count++;
        end else begin
          want = placements_due.pop_front();
          if (places_if.placed_length !== want.placed_length) begin
            $error("placed_length: expected %0d, got %0d", want.placed_length,
                   places_if.placed_length);
            fail_count++;
          end
          if (places_if.spaces_after !== want.spaces_after) begin
            $error("spaces_after: expected %0d, got %0d", want.spaces_after,
                   places_if.spaces_after);
            fail_count++;
          end
          if (places_if.line_end !== want.line_end) begin
            $error("line_end: expected %0d, got %0d", want.line_end, places_if.line_end);
            fail_count++;
          end
          if (places_if.too_long !== want.too_long) begin
            $error("too_long: expected %0d, got %0d", want.too_long, places_if.too_long);
            fail_count++;
          end
          if (places_if.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, places_if.run_last);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((words_if.valid && words_if.ready) || (places_if.valid && places_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("timeout: no transfer for %0d cycles", QUIET_MAX);
      $display("[text_line_justifier_unit] ERROR");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic add_word(int unsigned len, bit fin);
    word_item_t it;
    it.len = LEN_W'(len);
    it.fin = fin;
    text_words = {text_words, it};
  endtask

  task automatic settle();
    while (text_words.size() != 0 || words_if.valid || placements_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_width(int unsigned value);
    settle();
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= LINE_WIDTH_ADDR;
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    width_reg = LEN_W'(value);
    widths_used++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic add_random_word();
    int unsigned w;
    int unsigned r;
    int unsigned len;
    w = active_width();
    r = $urandom_range(0, 99);
    if (r < 5)       len = 0;
    else if (r < 13) len = $urandom_range(w + 1, 127);
    else if (r < 40) len = $urandom_range(1, w);
    else             len = $urandom_range(1, (w + 5) / 6);
    add_word(len, $urandom_range(0, 99) < 6);
  endtask

  initial begin
    int unsigned set_width_of [RAND_SETS];
    words_if.valid       = 1'b0;
    words_if.word_length = '0;
    words_if.final_word  = 1'b0;
    places_if.ready      = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: spreading, exact fill, single word, drops, final handling
    set_width(16);
    add_word(5, 0);  add_word(4, 0);  add_word(6, 0);  add_word(16, 0);
    add_word(3, 0);  add_word(3, 0);  add_word(3, 0);  add_word(3, 0);
    add_word(0, 0);  add_word(127, 0); add_word(64, 0); add_word(2, 1);
    add_word(7, 0);  add_word(20, 1); add_word(1, 1);  add_word(0, 1);
    set_width(1);
    add_word(1, 0);  add_word(2, 0);  add_word(1, 1);
    set_width(0);
    add_word(1, 0);  add_word(0, 1);
    set_width(64);
    add_word(1, 0);  add_word(64, 0); add_word(63, 1);
    // open line full: 32 one-letter words
    for (int k = 0; k < MAX_WORDS; k++) add_word(1, 0);
    add_word(5, 1);
    set_width(127);
    add_word(64, 0); add_word(65, 1);

    // random sets
    set_width_of = '{64, 23, 1, 127, 64, 5, 2, 40, 17};
    set_width_of[5] = $urandom_range(2, 63);
    set_width_of[8] = $urandom_range(1, 64);
    for (int s = 0; s < RAND_SETS; s++) begin
      set_width(set_width_of[s]);
      gap_pct   = (s == 4) ? 0 : 13;
      stall_pct = (s == 4) ? 0 : 13;
      for (int k = 0; k < SET_WORDS; k++) add_random_word();
      if (s == RAND_SETS - 1) add_word(1, 1);
    end

    settle();
    repeat (20) @(posedge clk);
    $display("run: %0d words over %0d width settings, %0d placed words, %0d lines, %0d drops",
             words_taken, widths_used, places_seen, lines_seen, dropped_seen);
    $display("leftover expectations: %0d, mismatches: %0d", placements_due.size(), fail_count);
    if (fail_count == 0 && placements_due.size() == 0)
      $display("[text_line_justifier_unit] OK");
    else
      $display("[text_line_justifier_unit] ERROR");
    $finish;
  end

endmodule
